// ----- design/wsd_pkg.sv -----
package wsd_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_B0   = 3'd0,
    PH_B1   = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // Result item kind
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_DRAIN  = 2'd2,
    KIND_HALT   = 2'd3
  } kind_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RESERVED = 3'd1,
    ERR_FRAGMENT = 3'd2,
    ERR_CTRL_LEN = 3'd3,
    ERR_MASKED   = 3'd4,
    ERR_OVERSIZE = 3'd5
  } err_t;

  // Opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // 7-bit length codes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [6:0] CTRL_MAX_LEN = 7'd125;

  // Header byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // Configuration registers
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PAYLOAD_CAPACITY = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REJECT_MASKED    = 4'd1;
  localparam logic [15:0] CAPACITY_RESET = 16'd255;
  localparam logic        REJECT_MASKED_RESET = 1'b1;

  typedef struct packed {
    logic [15:0] payload_capacity;
    logic        reject_masked;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [3:0]  frame_opcode;
    logic        frame_done;
    err_t        error_code;
    logic [63:0] payload_length;
  } result_t;

endpackage

// ----- design/websocket_frame_deframer_top.sv -----
// Channel  | Handshake                    | Payload
// ---------+------------------------------+---------------------------------------------
// in       | in_valid / in_stall          | stream_byte
// out      | out_valid / out_stall        | kind, data_byte, frame_opcode, frame_done,
//          |                              | error_code, payload_length
// cfg      | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// One byte is parsed per cycle while in_stall is low; its result item is registered
// in the output buffer. The parser state update and the unmask XOR sit between
// the parser state registers and the output register.
// A two-entry output buffer (register plus skid) lets a byte in while a result waits;
// in_stall rises only when both entries hold items. cfg_ready is always high.
// Reset (rst, synchronous) returns to the first header byte and clears the halt.
module websocket_frame_deframer_top #(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [3:0]  frame_opcode,
  output logic        frame_done,
  output logic [2:0]  error_code,
  output logic [63:0] payload_length,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wsd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  wsd_pkg::cfg_t    cfg;
  wsd_pkg::result_t result;
  wsd_pkg::result_t out_data;
  logic             accept;
  logic             full;

  // Configuration registers; writes to unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_capacity <= wsd_pkg::CAPACITY_RESET;
      cfg.reject_masked    <= wsd_pkg::REJECT_MASKED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsd_pkg::CFG_PAYLOAD_CAPACITY: cfg.payload_capacity <= cfg_data[15:0];
        wsd_pkg::CFG_REJECT_MASKED:    cfg.reject_masked    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Accept a byte whenever the output buffer has room
  assign in_stall = full;
  assign accept   = in_valid && !full;

  wsd_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (stream_byte),
    .cfg         (cfg),
    .result      (result)
  );

  wsd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Unpack the held item onto the field ports
  assign kind           = out_data.kind;
  assign data_byte      = out_data.data_byte;
  assign frame_opcode   = out_data.frame_opcode;
  assign frame_done     = out_data.frame_done;
  assign error_code     = out_data.error_code;
  assign payload_length = out_data.payload_length;

endmodule

// ----- design/wsd_parse.sv -----
module wsd_parse #(
  parameter int LENGTH_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        stream_byte,
  input  wsd_pkg::cfg_t     cfg,
  output wsd_pkg::result_t  result
);

  wsd_pkg::phase_t        phase, phase_next;
  logic [7:0]             first_header_byte, first_header_byte_next;
  logic [LENGTH_BITS-1:0] length_acc, length_acc_next;
  logic [3:0]             header_count, header_count_next;
  logic                   ext_long, ext_long_next;
  logic [31:0]            mask_word, mask_word_next;
  logic [LENGTH_BITS-1:0] position, position_next;
  logic                   mask_flag, mask_flag_next;
  logic                   drain_flag, drain_flag_next;
  logic                   halted, halted_next;

  logic                   check;
  logic [3:0]             need;
  logic [3:0]             op_next;
  logic [7:0]             key_byte;
  wsd_pkg::err_t          err;

  always_comb begin
    case (position[1:0])
      2'd0:    key_byte = mask_word[31:24];
      2'd1:    key_byte = mask_word[23:16];
      2'd2:    key_byte = mask_word[15:8];
      default: key_byte = mask_word[7:0];
    endcase
  end

  assign need = ext_long ? wsd_pkg::EXT64_BYTES : wsd_pkg::EXT16_BYTES;

  always_comb begin
    phase_next             = phase;
    first_header_byte_next = first_header_byte;
    length_acc_next        = length_acc;
    header_count_next      = header_count;
    ext_long_next          = ext_long;
    mask_word_next         = mask_word;
    position_next          = position;
    mask_flag_next         = mask_flag;
    drain_flag_next        = drain_flag;
    halted_next            = halted;
    check                  = 1'b0;
    err                    = wsd_pkg::ERR_NONE;
    result.kind            = wsd_pkg::KIND_HEADER;
    result.data_byte       = 8'h00;
    result.frame_done      = 1'b0;

    if (halted) begin
      result.kind = wsd_pkg::KIND_HALT;
    end else begin
      case (phase)
        wsd_pkg::PH_B0: begin
          first_header_byte_next = stream_byte;
          length_acc_next        = '0;
          phase_next             = wsd_pkg::PH_B1;
        end
        wsd_pkg::PH_B1: begin
          mask_flag_next  = stream_byte[7];
          length_acc_next = '0;
          if (stream_byte[6:0] == wsd_pkg::LEN_EXT16 ||
              stream_byte[6:0] == wsd_pkg::LEN_EXT64) begin
            ext_long_next     = (stream_byte[6:0] == wsd_pkg::LEN_EXT64);
            header_count_next = 4'd0;
            phase_next        = wsd_pkg::PH_EXT;
          end else begin
            length_acc_next = LENGTH_BITS'(stream_byte[6:0]);
            check           = 1'b1;
          end
        end
        wsd_pkg::PH_EXT: begin
          // saturate once the top byte is occupied
          if (|length_acc[LENGTH_BITS-1 -: 8]) begin
            length_acc_next = '1;
          end else begin
            length_acc_next = {length_acc[LENGTH_BITS-9:0], stream_byte};
          end
          header_count_next = header_count + 4'd1;
          if (header_count_next >= need) begin
            check = 1'b1;
          end
        end
        wsd_pkg::PH_KEY: begin
          mask_word_next    = {mask_word[23:0], stream_byte};
          header_count_next = header_count + 4'd1;
          if (header_count_next >= wsd_pkg::KEY_BYTES) begin
            header_count_next = 4'd0;
            if (length_acc == '0) begin
              phase_next        = wsd_pkg::PH_B0;
              result.frame_done = 1'b1;
            end else begin
              phase_next = wsd_pkg::PH_DATA;
            end
          end
        end
        wsd_pkg::PH_DATA: begin
          position_next     = position + LENGTH_BITS'(1);
          result.frame_done = (position_next >= length_acc);
          if (drain_flag) begin
            result.kind = wsd_pkg::KIND_DRAIN;
            if (result.frame_done) begin
              err = wsd_pkg::ERR_OVERSIZE;
            end
          end else begin
            result.kind      = wsd_pkg::KIND_DATA;
            result.data_byte = stream_byte ^ key_byte;
          end
          if (result.frame_done) begin
            phase_next = wsd_pkg::PH_B0;
          end
        end
        default: begin
          phase_next = wsd_pkg::PH_B0;
        end
      endcase
    end

    // Header validation on the byte that completes the length
    op_next = first_header_byte_next[3:0];
    if (check) begin
      if (|first_header_byte_next[6:4]) begin
        err = wsd_pkg::ERR_RESERVED;
      end else if (!first_header_byte_next[7] || op_next == wsd_pkg::OP_CONT) begin
        err = wsd_pkg::ERR_FRAGMENT;
      end else if ((op_next inside {wsd_pkg::OP_CLOSE, wsd_pkg::OP_PING, wsd_pkg::OP_PONG})
                   && length_acc_next > LENGTH_BITS'(wsd_pkg::CTRL_MAX_LEN)) begin
        err = wsd_pkg::ERR_CTRL_LEN;
      end else if (mask_flag_next && cfg.reject_masked) begin
        err = wsd_pkg::ERR_MASKED;
      end else begin
        mask_word_next    = '0;
        header_count_next = 4'd0;
        position_next     = '0;
        drain_flag_next   = (length_acc_next > LENGTH_BITS'(cfg.payload_capacity));
        if (mask_flag_next) begin
          phase_next = wsd_pkg::PH_KEY;
        end else if (length_acc_next == '0) begin
          phase_next        = wsd_pkg::PH_B0;
          result.frame_done = 1'b1;
        end else begin
          phase_next = wsd_pkg::PH_DATA;
        end
      end
    end

    // Protocol errors halt until reset
    if (err != wsd_pkg::ERR_NONE && err != wsd_pkg::ERR_OVERSIZE) begin
      result.kind       = wsd_pkg::KIND_HALT;
      result.frame_done = 1'b0;
      halted_next       = 1'b1;
    end

    result.error_code     = err;
    result.frame_opcode   = op_next;
    result.payload_length = 64'(length_acc_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wsd_pkg::PH_B0;
      first_header_byte <= 8'h00;
      length_acc        <= '0;
      header_count      <= 4'd0;
      ext_long          <= 1'b0;
      mask_word         <= 32'h0;
      position          <= '0;
      mask_flag         <= 1'b0;
      drain_flag        <= 1'b0;
      halted            <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      first_header_byte <= first_header_byte_next;
      length_acc        <= length_acc_next;
      header_count      <= header_count_next;
      ext_long          <= ext_long_next;
      mask_word         <= mask_word_next;
      position          <= position_next;
      mask_flag         <= mask_flag_next;
      drain_flag        <= drain_flag_next;
      halted            <= halted_next;
    end
  end

endmodule

// ----- design/wsd_out.sv -----
module wsd_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsd_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output wsd_pkg::result_t  out_data
);

  logic             skid_valid;
  wsd_pkg::result_t skid_data;
  logic             pop;

  assign full = skid_valid;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: refill output from skid first, else from the new item
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- tb/wsd_frame_check.sv -----
module wsd_frame_check #(
  parameter int LENGTH_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst,

  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [7:0]                         stream_byte,

  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [1:0]                         kind,
  input  logic [7:0]                         data_byte,
  input  logic [3:0]                         frame_opcode,
  input  logic                               frame_done,
  input  logic [2:0]                         error_code,
  input  logic [63:0]                        payload_length,

  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [wsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wsd_pkg::CFG_DATA_BITS-1:0]  cfg_data,

  output int                                 mismatches,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

  // Parser copy
  phase_t      parse_phase;
  logic [7:0]  hdr0;
  logic [63:0] length_so_far;
  logic [3:0]  hdr_count;
  logic [3:0]  ext_bytes;
  logic [31:0] key_word;
  logic [63:0] payload_pos;
  logic        masked;
  logic        draining;
  logic        halted;

  // Register copy
  logic [15:0] capacity;
  logic        reject_masked;

  result_t     pending_results[$];
  result_t     want;
  int unsigned result_no;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t: result %0d %s: got %0h, expected %0h", $realtime, result_no, what,
             got, exp_val);
    mismatches++;
  endtask

  // Length is complete: run the header checks in priority order and pick the next phase.
  function automatic err_t validate_header(output logic done);
    logic [3:0] op;
    op = hdr0[3:0];
    done = 1'b0;
    if (hdr0[6:4] != 3'b000) return ERR_RESERVED;
    if (!hdr0[7] || op == OP_CONT) return ERR_FRAGMENT;
    if ((op == OP_CLOSE || op == OP_PING || op == OP_PONG) && length_so_far > CTRL_MAX_LEN)
      return ERR_CTRL_LEN;
    if (masked && reject_masked) return ERR_MASKED;
    key_word = '0;
    hdr_count = '0;
    payload_pos = '0;
    draining = (length_so_far > capacity);
    if (masked) begin
      parse_phase = PH_KEY;
    end else if (length_so_far == 0) begin
      parse_phase = PH_B0;
      done = 1'b1;
    end else begin
      parse_phase = PH_DATA;
    end
    return ERR_NONE;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t    r;
    logic       done;
    err_t       err;
    logic [1:0] lane;
    r = '0;
    r.kind = KIND_HEADER;
    done = 1'b0;
    err = ERR_NONE;
    if (halted) begin
      r.kind = KIND_HALT;
    end else begin
      case (parse_phase)
        PH_B0: begin
          hdr0 = b;
          length_so_far = '0;
          parse_phase = PH_B1;
        end
        PH_B1: begin
          masked = b[7];
          length_so_far = '0;
          if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
            ext_bytes = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            hdr_count = '0;
            parse_phase = PH_EXT;
          end else begin
            length_so_far = 64'(b[6:0]);
            err = validate_header(done);
          end
        end
        PH_EXT: begin
          // saturate when the next byte would not fit in the length width
          if (length_so_far > (LEN_MASK >> 8)) length_so_far = LEN_MASK;
          else length_so_far = {length_so_far[55:0], b} & LEN_MASK;
          hdr_count = hdr_count + 4'd1;
          if (hdr_count >= ext_bytes) err = validate_header(done);
        end
        PH_KEY: begin
          key_word = {key_word[23:0], b};
          hdr_count = hdr_count + 4'd1;
          if (hdr_count >= KEY_BYTES) begin
            hdr_count = '0;
            if (length_so_far == 0) begin
              parse_phase = PH_B0;
              done = 1'b1;
            end else begin
              parse_phase = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          lane = payload_pos[1:0];
          payload_pos = payload_pos + 64'd1;
          done = (payload_pos >= length_so_far);
          if (draining) begin
            r.kind = KIND_DRAIN;
            if (done) err = ERR_OVERSIZE;
          end else begin
            r.kind = KIND_DATA;
            r.data_byte = b ^ key_word[8*(3-lane) +: 8];
          end
          if (done) parse_phase = PH_B0;
        end
        default: parse_phase = PH_B0;
      endcase
    end
    if (err != ERR_NONE && err != ERR_OVERSIZE) begin
      r.kind = KIND_HALT;
      done = 1'b0;
      halted = 1'b1;
    end
    r.frame_opcode = hdr0[3:0];
    r.frame_done = done;
    r.error_code = err;
    r.payload_length = length_so_far;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      parse_phase = PH_B0;
      hdr0 = '0;
      length_so_far = '0;
      hdr_count = '0;
      ext_bytes = '0;
      key_word = '0;
      payload_pos = '0;
      masked = 1'b0;
      draining = 1'b0;
      halted = 1'b0;
      capacity = CAPACITY_RESET;
      reject_masked = REJECT_MASKED_RESET;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no byte waiting", 64'(kind), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (kind !== want.kind)
            report_mismatch("kind", 64'(kind), 64'(want.kind));
          if (data_byte !== want.data_byte)
            report_mismatch("data_byte", 64'(data_byte), 64'(want.data_byte));
          if (frame_opcode !== want.frame_opcode)
            report_mismatch("frame_opcode", 64'(frame_opcode), 64'(want.frame_opcode));
          if (frame_done !== want.frame_done)
            report_mismatch("frame_done", 64'(frame_done), 64'(want.frame_done));
          if (error_code !== want.error_code)
            report_mismatch("error_code", 64'(error_code), 64'(want.error_code));
          if (payload_length !== want.payload_length)
            report_mismatch("payload_length", payload_length, want.payload_length);
        end
        result_no++;
      end
      if (in_valid && !in_stall)
        pending_results.push_back(parse_byte(stream_byte));
      // register writes only matter from the next header on
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PAYLOAD_CAPACITY) capacity = cfg_data[15:0];
        else if (cfg_index == CFG_REJECT_MASKED) reject_masked = cfg_data[0];
      end
    end
    pending <= pending_results.size();
  end

endmodule

// ----- tb/websocket_frame_deframer_top_tb.sv -----
module websocket_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  localparam int LENGTH_BITS = 64;
  localparam int ITEM_TARGET = 1050;   // stream bytes before the closing error frame
  localparam int PHASE_BYTES = 150;    // bytes per register setting
  localparam int QUIET_LIMIT = 4000;   // cycles without any handshake before giving up

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;

  // How a frame carries its length
  typedef enum int {ENC_SHORT, ENC_16, ENC_64} len_enc_t;

  // Receiver back-pressure patterns
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                stream_byte = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                kind;
  logic [7:0]                data_byte;
  logic [3:0]                frame_opcode;
  logic                      frame_done;
  logic [2:0]                error_code;
  logic [63:0]               payload_length;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int                        mismatches;
  int                        pending;

  int unsigned               bytes_sent;
  int unsigned               burst_left;
  int unsigned               quiet_cycles;
  logic [15:0]               cur_cap = CAPACITY_RESET;
  logic                      cur_rej = REJECT_MASKED_RESET;

  stall_mode_t               stall_mode;
  int unsigned               mode_left;
  int unsigned               stall_run;
  logic                      stall_next;

  websocket_frame_deframer_top #(.LENGTH_BITS(LENGTH_BITS)) dut (.*);

  wsd_frame_check #(.LENGTH_BITS(LENGTH_BITS)) frame_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: switch between back-pressure patterns at random intervals, and drop the
  // stall once stall_run reaches its limit.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      mode_left = 0;
      stall_run = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_TOGGLE));
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  stall_next = 1'b0;
        STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
        default:     stall_next = ~out_stall;
      endcase
      if (stall_run >= 12) stall_next = 1'b0;
      stall_run = stall_next ? stall_run + 1 : 0;
      out_stall <= stall_next;
    end
  end

  // Watchdog: any handshake on any channel resets the quiet count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte and hold it until the block takes it. At the start of each burst,
  // drop valid for a random gap (sometimes none, so long gap-free stretches occur).
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (in_stall);
    burst_left--;
    bytes_sent++;
  endtask

  // Stop sending and wait until every byte has produced its result item.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle.
  task automatic configure(input logic [15:0] cap, input logic rej);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PAYLOAD_CAPACITY;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_REJECT_MASKED;
    cfg_data <= {{(CFG_DATA_BITS-1){1'b0}}, rej};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_cap = cap;
    cur_rej = rej;
  endtask

  // Header bytes: first byte, length in the chosen form (big-endian), mask key if masked.
  task automatic send_header(input logic [7:0] first, input logic mbit,
                             input logic [63:0] len, input len_enc_t enc);
    logic [31:0] key;
    key = $urandom;
    send_byte(first);
    case (enc)
      ENC_SHORT: send_byte({mbit, len[6:0]});
      ENC_16: begin
        send_byte({mbit, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mbit, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (mbit)
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
  endtask

  // Well-formed final frame with random payload content.
  task automatic send_frame(input logic [3:0] op, input logic mbit, input logic [63:0] len,
                            input len_enc_t enc);
    send_header({1'b1, 3'b000, op}, mbit, len, enc);
    repeat (len) send_byte(8'($urandom));
  endtask

  // Random legal frame: mostly data opcodes and short payloads, lengths around the
  // capacity boundary when the capacity is small, every length form, masked frames
  // only while they are accepted.
  task automatic random_frame();
    logic [3:0]  op;
    logic        mbit;
    logic [63:0] len;
    len_enc_t    enc;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) op = $urandom_range(0, 1) ? OP_BINARY : OP_TEXT;
    else if (pick < 80) op = OP_CLOSE + 4'($urandom_range(0, 2));
    else if (pick < 90) op = 4'($urandom_range(3, 7));
    else op = 4'($urandom_range(11, 15));
    pick = $urandom_range(0, 99);
    if (pick < 50) len = $urandom_range(0, 6);
    else if (pick < 72) len = $urandom_range(7, 40);
    else if (pick < 90 && cur_cap <= 300)
      len = (cur_cap == 0) ? $urandom_range(0, 1) : cur_cap - 1 + $urandom_range(0, 2);
    else len = $urandom_range(100, 300);
    if (op >= OP_CLOSE && op <= OP_PONG && len > CTRL_MAX_LEN) len = CTRL_MAX_LEN;
    pick = $urandom_range(0, 99);
    if (len > CTRL_MAX_LEN) enc = (pick < 60) ? ENC_16 : ENC_64;
    else if (pick < 70) enc = ENC_SHORT;
    else enc = (pick < 85) ? ENC_16 : ENC_64;
    mbit = !cur_rej && $urandom_range(0, 1);
    send_frame(op, mbit, len, enc);
  endtask

  // A protocol error halts the block until reset, and reset happens once, so the run
  // ends with one error frame of a random class followed by bytes that must all come
  // back as halted.
  task automatic error_tail();
    err_t        fault;
    logic [7:0]  first;
    logic        mbit;
    logic [63:0] len;
    len_enc_t    enc;
    fault = err_t'($urandom_range(ERR_RESERVED, ERR_MASKED));
    enc = len_enc_t'($urandom_range(ENC_SHORT, ENC_64));
    case (enc)
      ENC_SHORT: len = $urandom_range(0, CTRL_MAX_LEN);
      ENC_16:    len = $urandom_range(0, 16'hFFFF);
      default:   len = {$urandom, $urandom};
    endcase
    mbit = 1'($urandom);
    first = 8'($urandom);
    case (fault)
      ERR_RESERVED: begin
        if (first[6:4] == 3'b000) first[4] = 1'b1;
      end
      ERR_FRAGMENT: begin
        first[6:4] = 3'b000;
        if ($urandom_range(0, 1)) first[7] = 1'b0;
        else first[3:0] = OP_CONT;
      end
      ERR_CTRL_LEN: begin
        first = {1'b1, 3'b000, OP_CLOSE + 4'($urandom_range(0, 2))};
        if (enc != ENC_64) begin
          enc = ENC_16;
          len = $urandom_range(126, 16'hFFFF);
        end else if (len <= CTRL_MAX_LEN) begin
          len = 64'd126;
        end
      end
      default: begin
        // keep the frame otherwise legal so the mask check is the one that trips
        first = {1'b1, 3'b000, $urandom_range(0, 1) ? OP_TEXT : OP_PING};
        if (enc == ENC_64) len = $urandom_range(0, CTRL_MAX_LEN);
        else len = len % (CTRL_MAX_LEN + 1);
        mbit = 1'b1;
        if (!cur_rej) configure(cur_cap, 1'b1);
      end
    endcase
    send_header(first, mbit, len, enc);
    repeat ($urandom_range(4, 10)) send_byte(8'($urandom));
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned phase_start;
    logic [15:0] cap_plan [6];
    logic        rej_plan [6];
    cap_plan = '{16'd0, 16'hFFFF, 16'd3, 16'd126, 16'd300, 16'd1};
    rej_plan = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    bytes_sent = 0;
    burst_left = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty text frame (done on the last header byte), short binary, each
    // control opcode, unknown opcodes, both extended-length forms.
    send_frame(OP_TEXT, 1'b0, 0, ENC_SHORT);
    send_frame(OP_BINARY, 1'b0, 2, ENC_SHORT);
    send_frame(OP_PING, 1'b0, 0, ENC_SHORT);
    send_frame(OP_PONG, 1'b0, 1, ENC_16);
    send_frame(OP_CLOSE, 1'b0, 2, ENC_SHORT);
    send_frame(4'hB, 1'b0, 1, ENC_64);
    send_frame(4'h3, 1'b0, 0, ENC_SHORT);
    // Masked frames accepted: drained with zero capacity, empty (done on the last
    // key byte), then unmasked delivery at full capacity.
    configure(16'd0, 1'b0);
    send_frame(OP_BINARY, 1'b1, 3, ENC_SHORT);
    send_frame(OP_TEXT, 1'b1, 0, ENC_16);
    configure(16'hFFFF, 1'b0);
    send_frame(OP_BINARY, 1'b1, 6, ENC_SHORT);

    // Random: walk through register settings, extremes first, then random ones.
    phase_no = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (phase_no < 6) configure(cap_plan[phase_no], rej_plan[phase_no]);
      else configure(16'($urandom_range(0, 64)), 1'($urandom));
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < ITEM_TARGET) begin
        random_frame();
        // now and then hold off until every result has drained
        if ($urandom_range(0, 19) == 0) settle();
      end
      phase_no++;
    end

    error_tail();
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
